[hdl/assert_macros.svh]
// Assertion macros used by the checker of the peak limiter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, off while reset is high.
`define SLIM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition in one cycle requires a consequence in the next one.
`define SLIM_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error(msg);

`endif

[hdl/slim_pkg.sv]
// Shared widths, constants and helpers of the stereo peak limiter.
`default_nettype none

package slim_pkg;

  localparam int SAMPLE_FRAC_BITS = 20;
  localparam int GAIN_FRAC_BITS   = 24;

  localparam int IN_W      = 24;
  localparam int OUT_W     = 22;
  localparam int MAG_W     = IN_W;
  localparam int GAIN_W    = GAIN_FRAC_BITS + 1;
  localparam int THR_W     = GAIN_W + SAMPLE_FRAC_BITS;
  localparam int MUL_W     = GAIN_W;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int QUO_W     = GAIN_W;
  localparam int DIV_CNT_W = $clog2(QUO_W);
  localparam int CNT_W     = 32;
  localparam int CFG_IDX_W = 2;

  // Fixed-point unity values
  localparam logic [GAIN_W-1:0] ONE_G = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
  localparam logic [MAG_W-1:0]  ONE_S = MAG_W'(1) << SAMPLE_FRAC_BITS;

  // Rounding offsets applied to products before dropping the gain fraction
  localparam logic [PROD_W-1:0] HALF_G   = PROD_W'(ONE_G >> 1);
  localparam logic [PROD_W-1:0] ROUND_UP = PROD_W'(ONE_G) - PROD_W'(1);

  // Output clamp limits
  localparam logic signed [OUT_W-1:0] OUT_POS = OUT_W'(ONE_S);
  localparam logic signed [OUT_W-1:0] OUT_NEG = -OUT_POS;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 2'd2;

  // Register reset values
  localparam logic [GAIN_W-1:0] RST_THRESHOLD = 25'd15938355;
  localparam logic [GAIN_W-1:0] RST_RELEASE   = 25'd3495;

  // Saturate a Q1.24 value to unity
  function automatic logic [GAIN_W-1:0] sat_unity(input logic [GAIN_W-1:0] v);
    sat_unity = (v > ONE_G) ? ONE_G : v;
  endfunction

  // Clamp a magnitude to 1.0 and apply the sign
  function automatic logic signed [OUT_W-1:0] enc_out(input logic [MAG_W-1:0] m,
                                                      input logic neg);
    logic [MAG_W-1:0] c;
    logic [OUT_W-1:0] u;
    c = (m > ONE_S) ? ONE_S : m;
    u = c[OUT_W-1:0];
    enc_out = neg ? $signed(OUT_W'(0) - u) : $signed(u);
  endfunction

endpackage

`default_nettype wire

[hdl/slim_mul.sv]
// Shared unsigned multiplier with a registered product.
`default_nettype none

module slim_mul (
  input  wire logic                       clk,
  input  wire logic [slim_pkg::MUL_W-1:0] a,
  input  wire logic [slim_pkg::MUL_W-1:0] b,
  output logic      [slim_pkg::PROD_W-1:0] product
);

  // Product is registered and lands in the cycle after the operands are presented
  always_ff @(posedge clk) begin
    product <= slim_pkg::PROD_W'(a) * slim_pkg::PROD_W'(b);
  end

endmodule

`default_nettype wire

[hdl/slim_div.sv]
// Restoring divider, one quotient bit per cycle, for the attack gain.
`default_nettype none

module slim_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [slim_pkg::THR_W-1:0] dividend,
  input  wire logic [slim_pkg::MAG_W-1:0] divisor,
  output logic                            done,
  output logic      [slim_pkg::QUO_W-1:0] quotient
);

  logic [slim_pkg::MAG_W-1:0]     rem;
  logic [slim_pkg::QUO_W-1:0]     low;
  logic [slim_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;
  logic [slim_pkg::MAG_W:0]       trial;
  logic                           ge;

  // Shift in the next dividend bit and test against the divisor
  always_comb begin
    trial = {rem, low[slim_pkg::QUO_W-1]};
    ge    = trial >= {1'b0, divisor};
  end

  // Quotient is known to fit in QUO_W bits, so the high dividend part
  // starts below the divisor.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= slim_pkg::MAG_W'(dividend[slim_pkg::THR_W-1:slim_pkg::QUO_W]);
        low  <= dividend[slim_pkg::QUO_W-1:0];
        cnt  <= slim_pkg::DIV_CNT_W'(slim_pkg::QUO_W - 1);
        busy <= 1'b1;
      end else if (busy) begin
        rem      <= ge ? slim_pkg::MAG_W'(trial - {1'b0, divisor})
                       : trial[slim_pkg::MAG_W-1:0];
        quotient <= {quotient[slim_pkg::QUO_W-2:0], ge};
        low      <= low << 1;
        cnt      <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[hdl/stereo_peak_limiter.sv]
// Top level of the stereo peak limiter: sequencer, state and registers.
//
// Usage: one stereo frame (left_in, right_in, signed Q3.20) is a request on
// in_valid/in_ready. Each frame gives one result on out_valid/out_ready:
// clamped samples, the gain used and the running statistics.
// Configuration writes come on cfg_valid/cfg_ready (always ready) with a
// register index on cfg_index: 0 enable, 1 threshold, 2 release coefficient.
// Write them only while no frame is in flight.
// Steps per frame, set by the one shared multiplier and the serial divider:
//   limiter off:              straight from accept to the output step
//   limiter on, release path: four multiplies in turn
//   limiter on, attack path:  25 divider steps plus setup
// in_ready is high only while the sequencer is idle; a new frame may be
// taken while the previous result still waits in the output register.
// If the receiver stalls, the finished frame holds in the final step until
// the output register frees up. Reset (rst, synchronous) restores unity
// gain, clears the statistics and loads the default register values.
`default_nettype none

module stereo_peak_limiter (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [slim_pkg::IN_W-1:0]     left_in,
  input  wire logic signed [slim_pkg::IN_W-1:0]     right_in,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed      [slim_pkg::OUT_W-1:0]    left_out,
  output logic signed      [slim_pkg::OUT_W-1:0]    right_out,
  output logic             [slim_pkg::GAIN_W-1:0]   gain_now,
  output logic                                      clipped,
  output logic             [slim_pkg::CNT_W-1:0]    clip_total,
  output logic             [slim_pkg::MAG_W-1:0]    peak_seen,
  output logic             [slim_pkg::GAIN_W-1:0]   lowest_gain,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic        [slim_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [slim_pkg::GAIN_W-1:0]   cfg_data
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_CMP  = 9'b000000010,
    S_DEC  = 9'b000000100,
    S_REL  = 9'b000001000,
    S_DIV  = 9'b000010000,
    S_SCL  = 9'b000100000,
    S_SCR  = 9'b001000000,
    S_SCE  = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t state, state_next;

  // Configuration registers
  logic                          limiter_enable;
  logic [slim_pkg::GAIN_W-1:0]   threshold;
  logic [slim_pkg::GAIN_W-1:0]   release_coeff;

  // Limiter state
  logic [slim_pkg::GAIN_W-1:0]   gain;
  logic [slim_pkg::GAIN_W-1:0]   min_gain;
  logic [slim_pkg::MAG_W-1:0]    peak_max;
  logic [slim_pkg::CNT_W-1:0]    clip_count;

  // Frame being worked on
  logic [slim_pkg::MAG_W-1:0]    lm, rm, peak_in, ls, rs;
  logic                          ln, rn;

  logic [slim_pkg::MAG_W-1:0]    mag_l, mag_r;
  logic [slim_pkg::THR_W-1:0]    thr_ext;
  logic [slim_pkg::GAIN_W-1:0]   coeff_sat;
  logic [slim_pkg::MUL_W-1:0]    mul_a, mul_b;
  logic [slim_pkg::PROD_W-1:0]   product;
  logic [slim_pkg::PROD_W-1:0]   rel_sum, scl_sum;
  logic [slim_pkg::GAIN_W:0]     gain_sum;
  logic                          attack;
  logic                          div_start, div_done;
  logic [slim_pkg::QUO_W-1:0]    quotient;
  logic                          out_free;
  logic                          clip;
  logic [slim_pkg::MAG_W-1:0]    opk;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  // Input magnitudes
  assign mag_l = left_in[slim_pkg::IN_W-1]  ? slim_pkg::MAG_W'(~left_in + 1'b1)
                                            : slim_pkg::MAG_W'(left_in);
  assign mag_r = right_in[slim_pkg::IN_W-1] ? slim_pkg::MAG_W'(~right_in + 1'b1)
                                            : slim_pkg::MAG_W'(right_in);

  // Saturated threshold aligned to the peak*gain product, and coefficient
  assign thr_ext   = {slim_pkg::sat_unity(threshold), {slim_pkg::SAMPLE_FRAC_BITS{1'b0}}};
  assign coeff_sat = slim_pkg::sat_unity(release_coeff);

  // Product post-processing: ceil for release, nearest for scaling
  assign rel_sum  = product + slim_pkg::ROUND_UP;
  assign scl_sum  = product + slim_pkg::HALF_G;
  assign gain_sum = {1'b0, gain}
                  + {1'b0, rel_sum[slim_pkg::GAIN_FRAC_BITS +: slim_pkg::GAIN_W]};
  assign attack   = (peak_in != '0) && (product > slim_pkg::PROD_W'(thr_ext));
  assign div_start = (state == S_DEC) && attack;

  // Statistics of the finished frame
  assign clip = (ls > slim_pkg::ONE_S) || (rs > slim_pkg::ONE_S);
  assign opk  = (ls > rs) ? ls : rs;

  // Multiplier operand select per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_CMP: begin
        mul_a = slim_pkg::MUL_W'(peak_in);
        mul_b = gain;
      end
      S_DEC: begin
        mul_a = slim_pkg::ONE_G - gain;
        mul_b = coeff_sat;
      end
      S_SCL: begin
        mul_a = slim_pkg::MUL_W'(lm);
        mul_b = gain;
      end
      S_SCR: begin
        mul_a = slim_pkg::MUL_W'(rm);
        mul_b = gain;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = limiter_enable ? S_CMP : S_FIN;
      S_CMP:  state_next = S_DEC;
      S_DEC:  state_next = attack ? S_DIV : S_REL;
      S_REL:  state_next = S_SCL;
      S_DIV:  if (div_done) state_next = S_SCL;
      S_SCL:  state_next = S_SCR;
      S_SCR:  state_next = S_SCE;
      S_SCE:  state_next = S_FIN;
      S_FIN:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Configuration writes; an index beyond the list is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      limiter_enable <= 1'b1;
      threshold      <= slim_pkg::RST_THRESHOLD;
      release_coeff  <= slim_pkg::RST_RELEASE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        slim_pkg::REG_ENABLE:    limiter_enable <= cfg_data[0];
        slim_pkg::REG_THRESHOLD: threshold      <= cfg_data;
        slim_pkg::REG_RELEASE:   release_coeff  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame capture and scaled magnitudes
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      lm      <= mag_l;
      rm      <= mag_r;
      ln      <= left_in[slim_pkg::IN_W-1];
      rn      <= right_in[slim_pkg::IN_W-1];
      peak_in <= (mag_l > mag_r) ? mag_l : mag_r;
      ls      <= mag_l;
      rs      <= mag_r;
    end else if (state == S_SCR) begin
      ls <= scl_sum[slim_pkg::GAIN_FRAC_BITS +: slim_pkg::MAG_W];
    end else if (state == S_SCE) begin
      rs <= scl_sum[slim_pkg::GAIN_FRAC_BITS +: slim_pkg::MAG_W];
    end
  end

  // Gain tracking: release toward unity or attack from the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      gain     <= slim_pkg::ONE_G;
      min_gain <= slim_pkg::ONE_G;
    end else if (state == S_REL) begin
      gain <= (gain_sum > {1'b0, slim_pkg::ONE_G}) ? slim_pkg::ONE_G
                                                   : gain_sum[slim_pkg::GAIN_W-1:0];
    end else if ((state == S_DIV) && div_done) begin
      gain <= quotient;
      if (quotient < min_gain) min_gain <= quotient;
    end
  end

  // Statistics and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      clip_count <= '0;
      peak_max   <= '0;
    end else begin
      if ((state == S_FIN) && out_free) begin
        if (clip && (clip_count != '1)) begin
          clip_count <= clip_count + 1'b1;
          clip_total <= clip_count + 1'b1;
        end else begin
          clip_total <= clip_count;
        end
        if (opk > peak_max) begin
          peak_max  <= opk;
          peak_seen <= opk;
        end else begin
          peak_seen <= peak_max;
        end
        left_out    <= slim_pkg::enc_out(ls, ln);
        right_out   <= slim_pkg::enc_out(rs, rn);
        gain_now    <= limiter_enable ? gain : slim_pkg::ONE_G;
        clipped     <= clip;
        lowest_gain <= min_gain;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  slim_mul u_mul (
    .clk     (clk),
    .a       (mul_a),
    .b       (mul_b),
    .product (product)
  );

  slim_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (thr_ext),
    .divisor  (peak_in),
    .done     (div_done),
    .quotient (quotient)
  );

endmodule

`default_nettype wire

[hdl/slim_chk.sv]
// Port-level checker for the stereo peak limiter, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module slim_chk (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 in_valid,
  input wire logic                                 in_ready,
  input wire logic signed [slim_pkg::IN_W-1:0]     left_in,
  input wire logic signed [slim_pkg::IN_W-1:0]     right_in,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic signed [slim_pkg::OUT_W-1:0]    left_out,
  input wire logic signed [slim_pkg::OUT_W-1:0]    right_out,
  input wire logic        [slim_pkg::GAIN_W-1:0]   gain_now,
  input wire logic                                 clipped,
  input wire logic        [slim_pkg::CNT_W-1:0]    clip_total,
  input wire logic        [slim_pkg::MAG_W-1:0]    peak_seen,
  input wire logic        [slim_pkg::GAIN_W-1:0]   lowest_gain,
  input wire logic                                 cfg_valid,
  input wire logic                                 cfg_ready,
  input wire logic        [slim_pkg::CFG_IDX_W-1:0] cfg_index,
  input wire logic        [slim_pkg::GAIN_W-1:0]   cfg_data
);

  // Accepting a frame takes the sequencer out of idle and drops in_ready
  `SLIM_ASSERT_NEXT(a_busy_after_req, clk, rst, in_valid && in_ready, !in_ready, "ready after request")

  // A stalled result stays valid and holds its left sample and clip total
  `SLIM_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(left_out) && $stable(clip_total), "stalled result changed")

  // Outputs stay within the clamp limits
  `SLIM_ASSERT(a_clamp, clk, rst, out_valid |-> (left_out <= slim_pkg::OUT_POS && left_out >= slim_pkg::OUT_NEG && right_out <= slim_pkg::OUT_POS && right_out >= slim_pkg::OUT_NEG), "clamp violated")

  // A clipped frame always shows a nonzero clip total
  `SLIM_ASSERT(a_clip_count, clk, rst, (out_valid && clipped) |-> (clip_total != '0), "clip not counted")

  // Lowest gain never exceeds the applied gain, which never exceeds unity
  `SLIM_ASSERT(a_gain_order, clk, rst, out_valid |-> (lowest_gain <= gain_now && gain_now <= slim_pkg::ONE_G), "gain order broken")

endmodule

bind stereo_peak_limiter slim_chk u_slim_chk (.*);

`default_nettype wire
